@@ hdl/swsr_pkg.sv @@
// swsr_pkg: state encoding, result kind codes and config register indexes for the window sender
// no dependencies
package swsr_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP_RD,
        S_DROP_CHK,
        S_CALC_SUM,
        S_CALC_MUL,
        S_CALC_CHK,
        S_DIV,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FILL,
        S_FINAL,
        S_DONE_EMIT,
        S_FLUSH
    } t_state;

    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_RETX   = 2'd1;
    localparam logic [1:0] KIND_FINAL  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [1:0] CFG_INIT_WIN = 2'd0;
    localparam logic [1:0] CFG_DEF_TMO  = 2'd1;
    localparam logic [1:0] CFG_CEIL     = 2'd2;

endpackage

@@ hdl/swsr_window.sv @@
// swsr_window: window entry store, one write port and one registered read port
// no dependencies
module swsr_window #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int SEQ_W = 24
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [SEQ_W-1:0] i_wseq,
    input  logic [31:0]      i_wtime,
    input  logic [4:0]       i_wwin,
    input  logic [AW-1:0]    i_raddr,
    output logic [SEQ_W-1:0] o_rseq,
    output logic [31:0]      o_rtime,
    output logic [4:0]       o_rwin
);

    logic [SEQ_W-1:0] r_seq  [DEPTH];
    logic [31:0]      r_time [DEPTH];
    logic [4:0]       r_win  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_seq[i_waddr]  <= i_wseq;
            r_time[i_waddr] <= i_wtime;
            r_win[i_waddr]  <= i_wwin;
        end
        o_rseq  <= r_seq[i_raddr];
        o_rtime <= r_time[i_raddr];
        o_rwin  <= r_win[i_raddr];
    end

endmodule

@@ hdl/sliding_window_sender_rto.sv @@
// sliding_window_sender_rto: windowed sender with adaptive retransmit timeout
// sequence: accept, then a read and a check per dropped entry until one is not yet acked, a
// timeout setup (sum, multiply, check) plus a reciprocal multiply when three samples exist and
// the estimate is below the ceiling, a read and a check per scanned entry, the sends of the fill,
// a final check and a flush; throughput: one event at a time, held further by output stalls
// reset: synchronous, clears control state; the window store is not cleared
// depends on swsr_pkg, swsr_window
module sliding_window_sender_rto #(
    parameter int WINDOW_DEPTH = 16,
    parameter int SEQ_BITS     = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_now_ms,
    input  logic [23:0] i_ack_sn,
    input  logic [31:0] i_echo_time_ms,
    input  logic [4:0]  i_segments_waiting,
    input  logic        i_source_exhausted,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [23:0] o_seq_num,
    output logic [4:0]  o_advertised_window,
    output logic        o_last
);

    localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LIM_W = $clog2(WINDOW_DEPTH + 1);
    localparam int MW    = LIM_W + 6;

    swsr_pkg::t_state r_state, n_state;

    logic [15:0]         r_def, r_ceil;
    logic [LIM_W-1:0]    r_lim, n_lim;
    logic [LIM_W-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]       r_head, n_head;
    logic [LIM_W-1:0]    r_idx, n_idx;
    logic [4:0]          r_handed, n_handed;
    logic [31:0]         r_s0, r_s1, r_s2;
    logic [1:0]          r_scnt;
    logic [SEQ_BITS-1:0] r_next, n_next;
    logic                r_final_sent, n_final_sent;
    logic                r_finished, n_finished;
    logic                r_exh;
    logic [31:0]         r_now;
    logic [SEQ_BITS-1:0] r_ack;
    logic [4:0]          r_wait;
    logic [34:0]         r_sum;
    logic [38:0]         r_t;
    logic [18:0]         r_divx, n_divx;
    logic [15:0]         r_tmo, n_tmo;

    logic                r_ov, r_pv;
    logic [1:0]          r_pkind;
    logic [SEQ_BITS-1:0] r_pseq;
    logic [4:0]          r_pwin;

    logic                e_go, flush_go, out_free, accept;
    logic [1:0]          e_kind;
    logic [SEQ_BITS-1:0] e_seq;
    logic [4:0]          e_win;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [SEQ_BITS-1:0] wseq, rseq;
    logic [31:0]         wtime, rtime;
    logic [4:0]          wwin, rwin;

    logic [SEQ_BITS-1:0] ack_in;
    logic [31:0]         age;
    logic                expired, fill_ok;
    logic [LIM_W-1:0]    lim_div, lim_scan;
    logic [MW-1:0]       lim_prod;
    logic [36:0]         div_prod;
    logic [15:0]         est_q;
    logic [23:0]         ceil_bound;
    logic [SEQ_BITS-1:0] seq_inc;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [LIM_W-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(b);
        if (s >= (AW+1)'(WINDOW_DEPTH)) begin
            s = s - (AW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [LIM_W-1:0] clamp_win(logic [4:0] w);
        logic [LIM_W-1:0] r;
        if (w == 5'd0) begin
            r = LIM_W'(1);
        end else if ({27'd0, w} > 32'(WINDOW_DEPTH)) begin
            r = LIM_W'(WINDOW_DEPTH);
        end else begin
            r = LIM_W'(w);
        end
        return r;
    endfunction

    swsr_window #(
        .DEPTH(WINDOW_DEPTH),
        .AW   (AW),
        .SEQ_W(SEQ_BITS)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wseq (wseq),
        .i_wtime(wtime),
        .i_wwin (wwin),
        .i_raddr(raddr),
        .o_rseq (rseq),
        .o_rtime(rtime),
        .o_rwin (rwin)
    );

    assign o_in_stall = (r_state != swsr_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign ack_in     = SEQ_BITS'({8'd0, i_ack_sn});
    assign age        = r_now - rtime;
    assign expired    = age > {16'd0, r_tmo};
    assign lim_prod   = MW'(r_lim) * MW'(43);
    assign lim_div    = LIM_W'(lim_prod >> 7);
    assign lim_scan   = expired ? ((lim_div == '0) ? LIM_W'(1) : lim_div) : r_lim;
    assign fill_ok    = (r_cnt < r_lim) && ({{(32-LIM_W){1'b0}}, r_cnt} < 32'(WINDOW_DEPTH))
                        && (r_handed < r_wait);
    // divide by 5 through a reciprocal, exact below 5 * 65536
    assign div_prod   = 37'(r_divx) * 37'd419431;
    assign est_q      = div_prod[36:21];
    assign ceil_bound = ({8'd0, r_ceil} + 24'd1) * 24'd80;
    assign seq_inc    = r_next + SEQ_BITS'(1);

    always_comb begin
        n_state      = r_state;
        n_lim        = r_lim;
        n_cnt        = r_cnt;
        n_head       = r_head;
        n_idx        = r_idx;
        n_handed     = r_handed;
        n_next       = r_next;
        n_final_sent = r_final_sent;
        n_finished   = r_finished;
        n_divx       = r_divx;
        n_tmo        = r_tmo;
        e_go         = 1'b0;
        e_kind       = swsr_pkg::KIND_NEW;
        e_seq        = '0;
        e_win        = 5'(r_lim);
        flush_go     = 1'b0;
        we           = 1'b0;
        waddr        = wrap_add(r_head, r_cnt);
        wseq         = '0;
        wtime        = r_now;
        wwin         = 5'(r_lim);
        raddr        = wrap_add(r_head, r_idx);
        unique case (r_state)
            swsr_pkg::S_IDLE: begin
                if (accept && !r_finished) begin
                    if (i_opcode && ack_in == '0) begin
                        n_state = swsr_pkg::S_DONE_EMIT;
                    end else if (i_opcode) begin
                        n_state = swsr_pkg::S_DROP_RD;
                    end else begin
                        n_state = swsr_pkg::S_CALC_SUM;
                    end
                end
            end
            swsr_pkg::S_DROP_RD: begin
                raddr = r_head;
                if (r_cnt == '0) begin
                    if (r_lim < LIM_W'(WINDOW_DEPTH)) n_lim = r_lim + LIM_W'(1);
                    n_state = swsr_pkg::S_CALC_SUM;
                end else begin
                    n_state = swsr_pkg::S_DROP_CHK;
                end
            end
            swsr_pkg::S_DROP_CHK: begin
                raddr = r_head;
                if (rseq <= r_ack) begin
                    n_head  = wrap_add(r_head, LIM_W'(1));
                    n_cnt   = r_cnt - LIM_W'(1);
                    n_state = swsr_pkg::S_DROP_RD;
                end else begin
                    if (r_lim < LIM_W'(WINDOW_DEPTH)) n_lim = r_lim + LIM_W'(1);
                    n_state = swsr_pkg::S_CALC_SUM;
                end
            end
            swsr_pkg::S_CALC_SUM: n_state = swsr_pkg::S_CALC_MUL;
            swsr_pkg::S_CALC_MUL: n_state = swsr_pkg::S_CALC_CHK;
            swsr_pkg::S_CALC_CHK: begin
                n_idx    = '0;
                n_handed = '0;
                if (r_scnt < 2'd3 || r_t >= {15'd0, ceil_bound}) begin
                    n_tmo   = r_def;
                    n_state = (r_cnt == '0) ? swsr_pkg::S_FILL : swsr_pkg::S_SCAN_RD;
                end else begin
                    n_divx  = r_t[22:4];
                    n_state = swsr_pkg::S_DIV;
                end
            end
            swsr_pkg::S_DIV: begin
                n_tmo   = (est_q == '0) ? r_def : est_q;
                n_state = (r_cnt == '0) ? swsr_pkg::S_FILL : swsr_pkg::S_SCAN_RD;
            end
            swsr_pkg::S_SCAN_RD: n_state = swsr_pkg::S_SCAN_CHK;
            swsr_pkg::S_SCAN_CHK: begin
                if (!expired || out_free) begin
                    if (expired) begin
                        n_lim  = lim_scan;
                        e_go   = 1'b1;
                        e_kind = swsr_pkg::KIND_RETX;
                        e_seq  = rseq;
                        e_win  = rwin;
                        we     = 1'b1;
                        waddr  = raddr;
                        wseq   = rseq;
                        wwin   = rwin;
                    end
                    if (r_idx + LIM_W'(1) >= lim_scan || r_idx + LIM_W'(1) >= r_cnt) begin
                        n_state = swsr_pkg::S_FILL;
                    end else begin
                        n_idx   = r_idx + LIM_W'(1);
                        n_state = swsr_pkg::S_SCAN_RD;
                    end
                end
            end
            swsr_pkg::S_FILL: begin
                if (!fill_ok) begin
                    n_state = swsr_pkg::S_FINAL;
                end else if (out_free) begin
                    e_go     = 1'b1;
                    e_seq    = r_next;
                    we       = 1'b1;
                    wseq     = r_next;
                    n_cnt    = r_cnt + LIM_W'(1);
                    n_handed = r_handed + 5'd1;
                    n_next   = (seq_inc == '0) ? SEQ_BITS'(1) : seq_inc;
                end
            end
            swsr_pkg::S_FINAL: begin
                if (r_final_sent || !r_exh || r_cnt != '0) begin
                    n_state = swsr_pkg::S_FLUSH;
                end else if (out_free) begin
                    e_go         = 1'b1;
                    e_kind       = swsr_pkg::KIND_FINAL;
                    we           = 1'b1;
                    n_cnt        = r_cnt + LIM_W'(1);
                    n_final_sent = 1'b1;
                    n_state      = swsr_pkg::S_FLUSH;
                end
            end
            swsr_pkg::S_DONE_EMIT: begin
                if (out_free) begin
                    e_go       = 1'b1;
                    e_kind     = swsr_pkg::KIND_DONE;
                    n_finished = 1'b1;
                    n_state    = swsr_pkg::S_FLUSH;
                end
            end
            swsr_pkg::S_FLUSH: begin
                if (!r_pv) begin
                    n_state = swsr_pkg::S_IDLE;
                end else if (out_free) begin
                    flush_go = 1'b1;
                    n_state  = swsr_pkg::S_IDLE;
                end
            end
            default: n_state = swsr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swsr_pkg::S_IDLE;
            r_def        <= 16'd100;
            r_ceil       <= 16'd2000;
            r_lim        <= clamp_win(5'd10);
            r_cnt        <= '0;
            r_head       <= '0;
            r_s0         <= '0;
            r_s1         <= '0;
            r_s2         <= '0;
            r_scnt       <= '0;
            r_next       <= SEQ_BITS'(1);
            r_final_sent <= 1'b0;
            r_finished   <= 1'b0;
            r_ov         <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_lim        <= n_lim;
            r_cnt        <= n_cnt;
            r_head       <= n_head;
            r_next       <= n_next;
            r_final_sent <= n_final_sent;
            r_finished   <= n_finished;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swsr_pkg::CFG_INIT_WIN: r_lim  <= clamp_win(i_cfg_data[4:0]);
                    swsr_pkg::CFG_DEF_TMO:  r_def  <= i_cfg_data;
                    swsr_pkg::CFG_CEIL:     r_ceil <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && !r_finished && i_opcode && ack_in != '0) begin
                r_s2 <= r_s1;
                r_s1 <= r_s0;
                r_s0 <= i_now_ms - i_echo_time_ms;
                if (r_scnt < 2'd3) r_scnt <= r_scnt + 2'd1;
            end
            if ((e_go && r_pv) || flush_go) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (e_go) begin
                r_pv <= 1'b1;
            end else if (flush_go) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now  <= i_now_ms;
            r_ack  <= ack_in;
            r_wait <= i_segments_waiting;
            r_exh  <= i_source_exhausted;
        end
        r_sum    <= {r_s1, 2'b00} + 35'(r_s1) + {2'b00, r_s0, 1'b0} + 35'(r_s2);
        r_t      <= 39'(r_sum) * 39'd13;
        r_idx    <= n_idx;
        r_handed <= n_handed;
        r_divx   <= n_divx;
        r_tmo    <= n_tmo;
        if (e_go) begin
            r_pkind <= e_kind;
            r_pseq  <= e_seq;
            r_pwin  <= e_win;
        end
        if ((e_go && r_pv) || flush_go) begin
            o_kind              <= r_pkind;
            o_seq_num           <= 24'(32'(r_pseq));
            o_advertised_window <= r_pwin;
            o_last              <= flush_go;
        end
    end

    assign o_out_valid = r_ov;

endmodule

@@ hdl/swsr_checker.sv @@
// swsr_checker: port level checks on the sender's result channel
// depends on swsr_pkg; bound to sliding_window_sender_rto
module swsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  i_kind,
    input logic [23:0] i_seq_num,
    input logic        i_last
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result transfer dropped while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == swsr_pkg::KIND_DONE |-> i_last && i_seq_num == 24'd0)
        else $error("done result malformed");

    a_final_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == swsr_pkg::KIND_FINAL |-> i_seq_num == 24'd0)
        else $error("final segment with nonzero number");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_sender_rto swsr_checker u_swsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_kind     (o_kind),
    .i_seq_num  (o_seq_num),
    .i_last     (o_last)
);
